// ===== hdl/dehys_pkg.sv =====
`default_nettype none
package dehys_pkg;

  localparam logic [15:0] TIMEOUT_MARK = 16'hFFFF;
  localparam logic [15:0] Q15_ONE      = 16'h8000;

  localparam logic [15:0] RST_AIR      = 16'd0;
  localparam logic [15:0] RST_TOUCH    = 16'd0;
  localparam logic [15:0] RST_ALPHA    = 16'd6554;
  localparam logic [15:0] RST_ON_THR   = 16'd19661;
  localparam logic [15:0] RST_OFF_THR  = 16'd13107;
  localparam logic [15:0] RST_HOLD     = 16'd60;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    CFG_AIR    = 3'd0,
    CFG_TOUCH  = 3'd1,
    CFG_CAL_EN = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_ON     = 3'd4,
    CFG_OFF    = 3'd5,
    CFG_HOLD   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DECIDE,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [15:0] air;
    logic [15:0] touch;
    logic        cal_en;
    logic [15:0] alpha;
    logic [15:0] on_thr;
    logic [15:0] off_thr;
    logic [15:0] hold;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic prep;
    logic div_step;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic decide;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic bypass;
    logic trivial;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/dehys_ctrl.sv =====
`default_nettype none
module dehys_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_fire_i,
  input  wire                out_free_i,
  input  dehys_pkg::status_t sts_i,
  output dehys_pkg::ctrl_t   ctrl_o
);
  import dehys_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        cnt_d = CNT_W'(DIV_STEPS - 1);
        if (sts_i.bypass) begin
          state_d = ST_WRITE;
        end else if (sts_i.trivial) begin
          state_d = ST_MUL_A;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_MUL_A;
      end
      ST_MUL_A:  state_d = ST_MUL_B;
      ST_MUL_B:  state_d = ST_SUM;
      ST_SUM:    state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.idle     = (state_q == ST_IDLE);
    ctrl_o.prep     = (state_q == ST_PREP);
    ctrl_o.div_step = (state_q == ST_DIV);
    ctrl_o.mul_a    = (state_q == ST_MUL_A);
    ctrl_o.mul_b    = (state_q == ST_MUL_B);
    ctrl_o.sum      = (state_q == ST_SUM);
    ctrl_o.decide   = (state_q == ST_DECIDE);
    ctrl_o.load_out = (state_q == ST_WRITE) && out_free_i;
  end

endmodule
`default_nettype wire

// ===== hdl/dehys_dp.sv =====
`default_nettype none
module dehys_dp (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  dehys_pkg::ctrl_t   ctrl_i,
  input  dehys_pkg::cfg_t    cfg_i,
  input  wire                in_fire_i,
  input  wire  [15:0]        distance_mm_i,
  input  wire  [31:0]        now_ms_i,
  output dehys_pkg::status_t sts_o,
  output logic               sample_valid_o,
  output logic [15:0]        engagement_o,
  output logic               string_active_o,
  output logic               state_changed_o
);
  import dehys_pkg::*;

  logic [15:0] dist_q;
  logic [31:0] now_q;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q;
  logic [15:0] eng_q, eng_d;
  logic [31:0] prod_q, acc_q;
  logic [15:0] level_q, level_d;
  logic        conf_q, conf_d;
  logic        cand_q, cand_d;
  logic [31:0] flip_q, flip_d;
  logic        chg_q, chg_d;

  logic [15:0] d_min, d_clamp;
  logic [15:0] alpha_c, alpha_inv;
  logic [15:0] mul_a_op, mul_b_op;
  logic [31:0] mul_p, acc_sum;
  logic        ge;
  logic [16:0] rem_sub;
  logic        wanted;
  logic [31:0] elapsed;

  assign sts_o.bypass  = (dist_q == TIMEOUT_MARK) || !cfg_i.cal_en;
  assign sts_o.trivial = (cfg_i.touch >= cfg_i.air);

  assign d_min   = (dist_q > cfg_i.air) ? cfg_i.air : dist_q;
  assign d_clamp = (d_min < cfg_i.touch) ? cfg_i.touch : d_min;

  assign ge      = (rem_q >= {1'b0, den_q});
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  assign alpha_c   = (cfg_i.alpha > Q15_ONE) ? Q15_ONE : cfg_i.alpha;
  assign alpha_inv = Q15_ONE - alpha_c;
  assign mul_a_op  = ctrl_i.mul_a ? alpha_c : alpha_inv;
  assign mul_b_op  = ctrl_i.mul_a ? eng_q : level_q;
  assign mul_p     = mul_a_op * mul_b_op;
  assign acc_sum   = acc_q + prod_q;

  assign wanted  = conf_q ? !(level_q < cfg_i.off_thr) : (level_q > cfg_i.on_thr);
  assign elapsed = now_q - flip_q;

  always_comb begin
    rem_d = rem_q;
    eng_d = eng_q;
    if (ctrl_i.prep) begin
      rem_d = {1'b0, cfg_i.air - d_clamp};
      eng_d = (cfg_i.touch == cfg_i.air) ? 16'd0 : Q15_ONE;
      if (!sts_o.trivial) eng_d = '0;
    end else if (ctrl_i.div_step) begin
      rem_d = {rem_sub[15:0], 1'b0};
      eng_d = {eng_q[14:0], ge};
    end
  end

  always_comb begin
    level_d = level_q;
    conf_d  = conf_q;
    cand_d  = cand_q;
    flip_d  = flip_q;
    chg_d   = chg_q;
    if (ctrl_i.prep) chg_d = 1'b0;
    if (ctrl_i.sum) level_d = acc_sum[30:15];
    if (ctrl_i.decide) begin
      if (wanted != cand_q) begin
        cand_d = wanted;
        flip_d = now_q;
      end else if ((elapsed > {16'd0, cfg_i.hold}) && (conf_q != cand_q)) begin
        conf_d = cand_q;
        chg_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      dist_q <= distance_mm_i;
      now_q  <= now_ms_i;
    end
    if (ctrl_i.prep) den_q <= cfg_i.air - cfg_i.touch;
    rem_q <= rem_d;
    eng_q <= eng_d;
    if (ctrl_i.mul_a || ctrl_i.mul_b) prod_q <= mul_p;
    if (ctrl_i.mul_b) acc_q <= prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      conf_q  <= 1'b0;
      cand_q  <= 1'b0;
      flip_q  <= '0;
      chg_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      conf_q  <= conf_d;
      cand_q  <= cand_d;
      flip_q  <= flip_d;
      chg_q   <= chg_d;
    end
  end

  assign sample_valid_o  = (dist_q != TIMEOUT_MARK);
  assign engagement_o    = cfg_i.cal_en ? level_q : 16'd0;
  assign string_active_o = conf_q;
  assign state_changed_o = chg_q;

endmodule
`default_nettype wire

// ===== hdl/distance_engagement_hysteresis.sv =====
`default_nettype none
// Channel | Handshake                    | Payload
// --------+------------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o      | distance_mm_i, now_ms_i
// out     | out_valid_o / out_stall_i    | sample_valid_o, engagement_o,
//         |                              | string_active_o, state_changed_o
// cfg     | cfg_we_i, cfg_idx_i          | cfg_data_i
//
// Calibrated request, touch below air: acceptance to result runs through setup,
// 16 restoring divider steps, two shared multiplier passes, sum, decision and load;
// a new request is taken only once the sequencer is back in idle. Touch at or above
// air skips the divider. Timeout and uncalibrated requests skip the arithmetic.
// Reset clears sequencer, smoothed level and debounce state; registers get defaults.
// A stalled result sits in the output register while the next request is taken.
module distance_engagement_hysteresis (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [15:0] distance_mm_i,
  input  wire  [31:0] now_ms_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        sample_valid_o,
  output logic [15:0] engagement_o,
  output logic        string_active_o,
  output logic        state_changed_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);
  import dehys_pkg::*;

  cfg_t    cfg_q;
  ctrl_t   ctrl;
  status_t sts;
  logic    in_fire;
  logic    out_free;
  logic    out_valid_q, out_valid_d;
  logic    res_sample_valid, res_string_active, res_state_changed;
  logic [15:0] res_engagement;

  assign in_stall_o = !ctrl.idle;
  assign in_fire    = in_valid_i && ctrl.idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.air     <= RST_AIR;
      cfg_q.touch   <= RST_TOUCH;
      cfg_q.cal_en  <= 1'b0;
      cfg_q.alpha   <= RST_ALPHA;
      cfg_q.on_thr  <= RST_ON_THR;
      cfg_q.off_thr <= RST_OFF_THR;
      cfg_q.hold    <= RST_HOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AIR:    cfg_q.air     <= cfg_data_i;
        CFG_TOUCH:  cfg_q.touch   <= cfg_data_i;
        CFG_CAL_EN: cfg_q.cal_en  <= cfg_data_i[0];
        CFG_ALPHA:  cfg_q.alpha   <= cfg_data_i;
        CFG_ON:     cfg_q.on_thr  <= cfg_data_i;
        CFG_OFF:    cfg_q.off_thr <= cfg_data_i;
        CFG_HOLD:   cfg_q.hold    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  dehys_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  dehys_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg_q),
    .in_fire_i       (in_fire),
    .distance_mm_i   (distance_mm_i),
    .now_ms_i        (now_ms_i),
    .sts_o           (sts),
    .sample_valid_o  (res_sample_valid),
    .engagement_o    (res_engagement),
    .string_active_o (res_string_active),
    .state_changed_o (res_state_changed)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      sample_valid_o  <= res_sample_valid;
      engagement_o    <= res_engagement;
      string_active_o <= res_string_active;
      state_changed_o <= res_state_changed;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== bench/tb_distance_engagement_hysteresis.sv =====
`default_nettype none
module tb_distance_engagement_hysteresis;
  import dehys_pkg::*;

  localparam logic [2:0] CFG_UNUSED    = 3'd7;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] engagement;
    logic        string_active;
    logic        state_changed;
  } result_t;

  typedef struct packed {
    logic [15:0] dist_mm;
    logic [31:0] stamp;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] distance_mm = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        sample_valid;
  logic [15:0] engagement;
  logic        string_active;
  logic        state_changed;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  sample_t     pending_samples[$];
  result_t     expected_results[$];
  logic        req_taken = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms = '0;

  // shadow of the block's registers and debounce state
  cfg_t        regs = '{air: RST_AIR, touch: RST_TOUCH, cal_en: 1'b0, alpha: RST_ALPHA,
                        on_thr: RST_ON_THR, off_thr: RST_OFF_THR, hold: RST_HOLD};
  logic [15:0] level = '0;
  logic        confirmed = 1'b0;
  logic        candidate = 1'b0;
  logic [31:0] flip_ms = '0;

  distance_engagement_hysteresis u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .distance_mm_i   (distance_mm),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_valid_o  (sample_valid),
    .engagement_o    (engagement),
    .string_active_o (string_active),
    .state_changed_o (state_changed),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] raw_level(logic [15:0] dist_mm);
    logic [31:0] d;
    logic [31:0] q;
    if (regs.air == regs.touch) return 32'd0;
    if (regs.touch > regs.air) return 32'(Q15_ONE);
    d = 32'(dist_mm);
    if (d > regs.air) d = regs.air;
    if (d < regs.touch) d = regs.touch;
    q = ((32'(regs.air) - d) * 32'(Q15_ONE)) / (32'(regs.air) - 32'(regs.touch));
    return (q > 32'(Q15_ONE)) ? 32'(Q15_ONE) : q;
  endfunction

  function automatic result_t predict_sample(logic [15:0] dist_mm, logic [31:0] stamp);
    result_t     r;
    logic [31:0] a;
    logic [31:0] acc;
    logic        want;
    r = '0;
    if (dist_mm == TIMEOUT_MARK) begin
      r.engagement    = regs.cal_en ? level : 16'd0;
      r.string_active = confirmed;
      return r;
    end
    r.sample_valid = 1'b1;
    if (!regs.cal_en) begin
      r.string_active = confirmed;
      return r;
    end
    a     = (regs.alpha > Q15_ONE) ? 32'(Q15_ONE) : 32'(regs.alpha);
    acc   = a * raw_level(dist_mm) + (32'(Q15_ONE) - a) * 32'(level);
    level = acc[30:15];
    want  = confirmed;
    if (!confirmed && level > regs.on_thr) begin
      want = 1'b1;
    end else if (confirmed && level < regs.off_thr) begin
      want = 1'b0;
    end
    if (want != candidate) begin
      candidate = want;
      flip_ms   = stamp;
    end
    if ((stamp - flip_ms) > 32'(regs.hold) && confirmed != candidate) begin
      confirmed       = candidate;
      r.state_changed = 1'b1;
    end
    r.engagement    = level;
    r.string_active = confirmed;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch_ports
    result_t want;
    req_taken <= in_valid && !in_stall;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_AIR:    regs.air     = cfg_data;
        CFG_TOUCH:  regs.touch   = cfg_data;
        CFG_CAL_EN: regs.cal_en  = cfg_data[0];
        CFG_ALPHA:  regs.alpha   = cfg_data;
        CFG_ON:     regs.on_thr  = cfg_data;
        CFG_OFF:    regs.off_thr = cfg_data;
        CFG_HOLD:   regs.hold    = cfg_data;
        default: ;
      endcase
    end
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("sample_valid", want.sample_valid, sample_valid);
        check_field("engagement", want.engagement, engagement);
        check_field("string_active", want.string_active, string_active);
        check_field("state_changed", want.state_changed, state_changed);
      end
    end
    if (in_valid && !in_stall) begin
      expected_results.push_back(predict_sample(distance_mm, now_ms));
    end
  end

  always @(negedge clk) begin : drive_requests
    sample_t s;
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
        s = pending_samples.pop_front();
        in_valid    <= 1'b1;
        distance_mm <= s.dist_mm;
        now_ms      <= s.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen = hold_off_reqs;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_sample(logic [15:0] dist_mm, logic [31:0] stamp);
    pending_samples.push_back('{dist_mm: dist_mm, stamp: stamp});
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_setting(logic [15:0] air, logic [15:0] touch, logic en,
                               logic [15:0] alpha, logic [15:0] on_thr,
                               logic [15:0] off_thr, logic [15:0] hold);
    wait_idle();
    write_reg(CFG_AIR, air);
    write_reg(CFG_TOUCH, touch);
    write_reg(CFG_CAL_EN, {15'($urandom_range(0, 32767)), en});
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_ON, on_thr);
    write_reg(CFG_OFF, off_thr);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_UNUSED, 16'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, int air, int touch, int hold);
    int   lo;
    int   hi;
    int   span;
    int   d;
    int   pick;
    logic hand;
    lo   = (touch < air) ? touch : air;
    hi   = (touch < air) ? air : touch;
    span = hi - lo;
    hand = 1'($urandom_range(0, 1));
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) hand = !hand;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        d = int'(TIMEOUT_MARK);
      end else if (pick < 12) begin
        d = $urandom_range(0, 65535);
      end else if (pick < 20) begin
        d = hand ? $urandom_range(0, lo) : $urandom_range(hi, 65534);
      end else begin
        d = hand ? lo + $urandom_range(0, span / 3) : hi - $urandom_range(0, span / 3);
      end
      if ($urandom_range(0, 99) < 3) begin
        clock_ms = $urandom();
      end else begin
        clock_ms += $urandom_range(0, hold + hold / 2 + 3);
      end
      push_sample(16'(d), clock_ms);
    end
  endtask

  initial begin : stimulus
    int unsigned air;
    int unsigned touch;
    int unsigned alpha;
    int unsigned on_thr;
    int unsigned hold;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // uncalibrated after reset
    push_sample(16'd0, 32'd0);
    push_sample(16'd65534, 32'hFFFF_FFFF);
    push_sample(TIMEOUT_MARK, 32'd5);

    // instant smoothing, no hold, timestamps across the wrap
    apply_setting(16'd400, 16'd50, 1'b1, Q15_ONE, RST_ON_THR, RST_OFF_THR, 16'd0);
    push_sample(16'd400, 32'hFFFF_FFFC);
    push_sample(16'd50, 32'hFFFF_FFFD);
    push_sample(16'd50, 32'hFFFF_FFFE);
    push_sample(TIMEOUT_MARK, 32'hFFFF_FFFF);
    push_sample(16'd0, 32'h0000_0000);
    push_sample(16'd65534, 32'h0000_0001);
    push_sample(16'd65534, 32'h0000_0002);
    push_sample(16'd225, 32'h0000_0003);

    // equal calibration distances, alpha beyond one, longest hold
    apply_setting(16'd300, 16'd300, 1'b1, 16'hFFFF, RST_ON_THR, RST_OFF_THR, 16'hFFFF);
    push_sample(16'd300, 32'd10);
    push_sample(16'd0, 32'd20);

    // touch above air, thresholds at the extremes
    apply_setting(16'd0, 16'd65534, 1'b1, Q15_ONE, 16'd0, Q15_ONE, 16'd0);
    push_sample(16'd1000, 32'd100);
    push_sample(16'd65534, 32'd200);
    push_sample(16'd0, 32'd300);
    apply_setting(16'd0, 16'd65534, 1'b1, Q15_ONE, 16'hFFFF, 16'hFFFF, 16'd0);
    push_sample(16'd5, 32'd400);
    push_sample(16'd6, 32'd500);
    apply_setting(16'd1000, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    push_sample(16'd0, 32'd600);
    push_sample(16'd1000, 32'd700);

    clock_ms = 32'hFFFF_0000;
    for (int phase = 0; phase < 6; phase++) begin
      air    = $urandom_range(1, 65534);
      touch  = $urandom_range(0, air - 1);
      alpha  = (phase == 2) ? 32'hFFFF : $urandom_range(2000, 32768);
      on_thr = $urandom_range(8192, 30000);
      hold   = (phase == 3) ? 32'hFFFF : $urandom_range(0, 150);
      if (phase == 0) begin
        air   = $urandom_range(20, 200);
        touch = $urandom_range(0, 10);
      end
      if (phase == 5) begin
        {air, touch} = {touch, air};
      end
      apply_setting(16'(air), 16'(touch), phase != 4, 16'(alpha), 16'(on_thr),
                    16'($urandom_range(1000, on_thr)), 16'(hold));
      no_idle = (phase == 1);
      if (phase == 3) hold_off_reqs++;
      run_random((phase == 4) ? 100 : 300, air, touch, hold);
      wait_idle();
      no_idle = 1'b0;
    end

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/dehys_pkg.sv
hdl/dehys_ctrl.sv
hdl/dehys_dp.sv
hdl/distance_engagement_hysteresis.sv
bench/tb_distance_engagement_hysteresis.sv
